// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on the rising edge and muted during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define MLFT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define MLFT_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication.
`define MLFT_ASSERT_NXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== hw/rtl/mlft_pkg.sv =====
`default_nettype none
package mlft_pkg;

   localparam logic [15:0] BPDU_TYPE = 16'h9946;

   localparam logic [2:0] ACT_DROP    = 3'd0;
   localparam logic [2:0] ACT_UNICAST = 3'd1;
   localparam logic [2:0] ACT_FLOOD   = 3'd2;
   localparam logic [2:0] ACT_STP     = 3'd3;
   localparam logic [2:0] ACT_UNKNOWN = 3'd4;
   localparam logic [2:0] ACT_DONE    = 3'd5;

   localparam logic [2:0] LRN_NONE    = 3'd0;
   localparam logic [2:0] LRN_ADDED   = 3'd1;
   localparam logic [2:0] LRN_REFRESH = 3'd2;
   localparam logic [2:0] LRN_MOVED   = 3'd3;
   localparam logic [2:0] LRN_FULL    = 3'd4;

   localparam logic [1:0] FUNC_FRAME = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;
   localparam logic [1:0] FUNC_PURGE = 2'd3;

   localparam logic [1:0] REG_ATTACHED = 2'd0;
   localparam logic [1:0] REG_LEARN    = 2'd1;
   localparam logic [1:0] REG_FORWARD  = 2'd2;
   localparam logic [1:0] REG_AGE      = 2'd3;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_MATCH = 3'd1,
      OP_LEARN = 3'd2,
      OP_AGE   = 3'd3,
      OP_FLUSH = 3'd4,
      OP_PURGE = 3'd5,
      OP_SHIFT = 3'd6
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        hit_any;
   } cell_cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SRC  = 7'b0000010,
      ST_LRN  = 7'b0000100,
      ST_DST  = 7'b0001000,
      ST_FWD  = 7'b0010000,
      ST_KILL = 7'b0100000,
      ST_CNT  = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mlft_cell.sv =====
`default_nettype none
module mlft_cell import mlft_pkg::*; #(
   parameter int TIME_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_cmd_type         cmd,
   input  wire logic [47:0]          key,
   input  wire logic [3:0]           port,
   input  wire logic [TIME_BITS-1:0] now,
   input  wire logic [15:0]          limit,
   input  wire logic                 free_in,
   output logic                      free_out,
   input  wire logic                 kill_up,
   output logic                      kill_out,
   output logic                      match_o,
   output logic [3:0]                port_o
);

   localparam int AGE_W = (TIME_BITS > 16) ? TIME_BITS : 16;

   logic                 valid_ff, valid_in;
   logic                 match_ff, match_in;
   logic                 first_ff, first_in;
   logic                 kill_ff, kill_in;
   logic [47:0]          mac_ff, mac_in;
   logic [3:0]           port_ff, port_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic [TIME_BITS-1:0] diff;
   logic                 old;

   assign diff     = now - stamp_ff;
   assign old      = AGE_W'(diff) >= AGE_W'(limit);
   assign free_out = free_in | ~valid_ff;
   assign kill_out = kill_ff;
   assign match_o  = match_ff;
   assign port_o   = match_ff ? port_ff : 4'd0;

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      first_in = first_ff;
      kill_in  = kill_ff;
      mac_in   = mac_ff;
      port_in  = port_ff;
      stamp_in = stamp_ff;
      unique case (cmd.op)
         OP_MATCH: begin
            match_in = valid_ff && (mac_ff == key);
            first_in = ~valid_ff & ~free_in;
         end
         OP_LEARN: begin
            if (match_ff) begin
               port_in  = port;
               stamp_in = now;
            end else if (!cmd.hit_any && first_ff) begin
               valid_in = 1'b1;
               mac_in   = key;
               port_in  = port;
               stamp_in = now;
            end
         end
         OP_AGE: begin
            kill_in  = valid_ff & old;
            valid_in = valid_ff & ~old;
         end
         OP_FLUSH: begin
            kill_in  = valid_ff;
            valid_in = 1'b0;
         end
         OP_PURGE: begin
            kill_in  = valid_ff && (port_ff == port);
            valid_in = valid_ff && (port_ff != port);
         end
         OP_SHIFT: kill_in = kill_up;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         first_ff <= 1'b0;
         kill_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         first_ff <= first_in;
         kill_ff  <= kill_in;
      end
      mac_ff   <= mac_in;
      port_ff  <= port_in;
      stamp_ff <= stamp_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/mac_learning_forwarding_table.sv =====
// Channel   Ports                           Handshake
// request   req_func .. req_ether_type      start & !busy
// response  rsp_action .. rsp_removed_count rsp_strobe, one cycle, no stall
// csr       csr_index, csr_wdata            csr_valid & csr_ready
// Frame: accept to strobe passes the states source match, learn write,
//   destination match and decide, with the row of entry cells doing one compare per cycle.
// Tick, flush, purge: a kill pass over all cells, then a count pass in which removed
//   entries are counted as kill flags shift down the cell row one per cycle.
// Synchronous reset empties the table at once; no clearing pass.
// busy stays high until the strobe cycle; results cannot be held off.
`default_nettype none
`include "assert_macros.svh"
module mac_learning_forwarding_table import mlft_pkg::*; #(
   parameter int NUM_PORTS     = 16,
   parameter int TABLE_ENTRIES = 256,
   parameter int TIME_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_in_port,
   input  wire logic [47:0] req_dst_mac,
   input  wire logic [47:0] req_src_mac,
   input  wire logic [15:0] req_ether_type,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_action,
   output logic [15:0]      rsp_out_ports,
   output logic [2:0]       rsp_learn_result,
   output logic [8:0]       rsp_removed_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam logic [15:0] PM = (NUM_PORTS >= 16) ? 16'hFFFF
                                : 16'((1 << NUM_PORTS) - 1);
   localparam int CW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

   state_type            state_ff, state_in;
   logic [15:0]          att_ff, lrn_ff, fwd_ff, age_ff;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [1:0]           func_ff;
   logic [3:0]           port_ff;
   logic [47:0]          dst_ff, src_ff;
   logic [15:0]          etype_ff;
   logic [2:0]           lres_ff, lres_in;
   logic [8:0]           rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 strobe_ff, strobe_in;
   logic [2:0]           act_ff, act_in;
   logic [15:0]          ports_ff, ports_in;

   cell_cmd_type         cmd;
   logic [47:0]          key;
   logic [TABLE_ENTRIES:0] free_c;
   logic [TABLE_ENTRIES:0] kill_c;
   logic [TABLE_ENTRIES-1:0] match_v;
   logic [3:0]           port_v [TABLE_ENTRIES];
   logic                 hit_any;
   logic [3:0]           hit_port;

   logic [15:0]          pbit, ob;
   logic                 unknown, bpdu, do_learn;

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_action = act_ff;
   assign rsp_out_ports = ports_ff;
   assign rsp_learn_result = lres_ff;
   assign rsp_removed_count = rem_ff;

   assign pbit     = 16'd1 << port_ff;
   assign unknown  = ((pbit & PM & att_ff) == 16'd0);
   assign bpdu     = (etype_ff == BPDU_TYPE);
   assign do_learn = ~unknown & ~bpdu & lrn_ff[port_ff] & ~src_ff[40];
   assign ob       = 16'd1 << hit_port;

   assign free_c[0] = 1'b0;
   assign kill_c[TABLE_ENTRIES] = 1'b0;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      mlft_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .key      (key),
         .port     (port_ff),
         .now      (tick_ff),
         .limit    (age_ff),
         .free_in  (free_c[g]),
         .free_out (free_c[g+1]),
         .kill_up  (kill_c[g+1]),
         .kill_out (kill_c[g]),
         .match_o  (match_v[g]),
         .port_o   (port_v[g])
      );
   end

   always_comb begin
      hit_any  = |match_v;
      hit_port = 4'd0;
      for (int i = 0; i < TABLE_ENTRIES; i++) hit_port = hit_port | port_v[i];
   end

   always_comb begin
      cmd.op      = OP_NOP;
      cmd.hit_any = hit_any;
      key         = src_ff;
      unique case (state_ff)
         ST_SRC: cmd.op = OP_MATCH;
         ST_LRN: cmd.op = do_learn ? OP_LEARN : OP_NOP;
         ST_DST: begin
            cmd.op = OP_MATCH;
            key    = dst_ff;
         end
         ST_KILL: begin
            case (func_ff)
               FUNC_TICK:  cmd.op = OP_AGE;
               FUNC_FLUSH: cmd.op = OP_FLUSH;
               default:    cmd.op = OP_PURGE;
            endcase
         end
         ST_CNT: cmd.op = OP_SHIFT;
         default: ;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      lres_in   = lres_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      act_in    = act_ff;
      ports_in  = ports_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lres_in = LRN_NONE;
               rem_in  = 9'd0;
               cnt_in  = '0;
               if (req_func == FUNC_FRAME) begin
                  state_in = ST_SRC;
               end else begin
                  state_in = ST_KILL;
                  if (req_func == FUNC_TICK) tick_in = tick_ff + 1'b1;
               end
            end
         end
         ST_SRC: state_in = ST_LRN;
         ST_LRN: begin
            state_in = ST_DST;
            if (do_learn) begin
               if (hit_any) lres_in = (hit_port == port_ff) ? LRN_REFRESH : LRN_MOVED;
               else         lres_in = free_c[TABLE_ENTRIES] ? LRN_ADDED : LRN_FULL;
            end
         end
         ST_DST: state_in = ST_FWD;
         ST_FWD: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            ports_in  = 16'd0;
            if (unknown)                   act_in = ACT_UNKNOWN;
            else if (bpdu)                 act_in = ACT_STP;
            else if (!fwd_ff[port_ff])     act_in = ACT_DROP;
            else if (dst_ff[40] || !hit_any) begin
               act_in   = ACT_FLOOD;
               ports_in = fwd_ff & att_ff & PM & ~pbit;
            end else if (hit_port == port_ff ||
                         (ob & PM & att_ff & fwd_ff) == 16'd0) begin
               act_in = ACT_DROP;
            end else begin
               act_in   = ACT_UNICAST;
               ports_in = ob;
            end
         end
         ST_KILL: state_in = ST_CNT;
         ST_CNT: begin
            if (kill_c[0] && rem_ff != 9'd511) rem_in = rem_ff + 9'd1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               act_in    = ACT_DONE;
               ports_in  = 16'd0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tick_ff   <= '0;
         strobe_ff <= 1'b0;
         att_ff    <= 16'd0;
         lrn_ff    <= 16'd0;
         fwd_ff    <= 16'd0;
         age_ff    <= 16'd7;
      end else begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_ATTACHED: att_ff <= csr_wdata;
               REG_LEARN:    lrn_ff <= csr_wdata;
               REG_FORWARD:  fwd_ff <= csr_wdata;
               REG_AGE:      age_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (state_ff == ST_IDLE && start) begin
         func_ff  <= req_func;
         port_ff  <= req_in_port;
         dst_ff   <= req_dst_mac;
         src_ff   <= req_src_mac;
         etype_ff <= req_ether_type;
      end
      lres_ff  <= lres_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      act_ff   <= act_in;
      ports_ff <= ports_in;
   end

   `MLFT_ASSERT(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `MLFT_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy, "strobe while busy")
   `MLFT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accept not followed by busy")
   `MLFT_ASSERT_IMP(a_frame_no_removed, clock, reset, rsp_strobe && rsp_action != ACT_DONE, rsp_removed_count == 9'd0, "frame reports removals")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import mlft_pkg::*;

   localparam int ENTRIES = 256;

   typedef struct {
      logic [1:0]  func;
      logic [3:0]  in_port;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
   } frame_req_type;

   typedef struct {
      logic [2:0]  action;
      logic [15:0] out_ports;
      logic [2:0]  learn_result;
      logic [8:0]  removed_count;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = '0;
   logic [3:0]  req_in_port = '0;
   logic [47:0] req_dst_mac = '0;
   logic [47:0] req_src_mac = '0;
   logic [15:0] req_ether_type = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_action;
   logic [15:0] rsp_out_ports;
   logic [2:0]  rsp_learn_result;
   logic [8:0]  rsp_removed_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   mac_learning_forwarding_table uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow bridge state
   logic        tbl_valid [ENTRIES];
   logic [47:0] tbl_mac [ENTRIES];
   logic [3:0]  tbl_port [ENTRIES];
   logic [15:0] tbl_stamp [ENTRIES];
   logic [15:0] tick_cnt;
   logic [15:0] attached_q, learn_q, forward_q, age_limit_q;

   frame_req_type pending_reqs[$];
   verdict_type   expected_verdicts[$];
   int         errors = 0;
   int         idle_pct = 0;
   logic       drain_done = 1'b0;

   function automatic int lookup_mac(logic [47:0] mac);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i] && tbl_mac[i] == mac) return i;
      return -1;
   endfunction

   function automatic verdict_type bridge_step(frame_req_type r);
      verdict_type v;
      logic [15:0] pbit;
      int hit;
      v = '{ACT_DROP, 16'd0, LRN_NONE, 9'd0};
      pbit = 16'd1 << r.in_port;
      if (r.func == FUNC_FRAME) begin
         if ((pbit & attached_q) == 0) begin
            v.action = ACT_UNKNOWN;
         end else if (r.ether_type == BPDU_TYPE) begin
            v.action = ACT_STP;
         end else begin
            if ((learn_q & pbit) != 0 && !r.src_mac[40]) begin
               hit = lookup_mac(r.src_mac);
               if (hit >= 0) begin
                  tbl_stamp[hit] = tick_cnt;
                  if (tbl_port[hit] == r.in_port) v.learn_result = LRN_REFRESH;
                  else begin
                     tbl_port[hit] = r.in_port;
                     v.learn_result = LRN_MOVED;
                  end
               end else begin
                  v.learn_result = LRN_FULL;
                  for (int i = 0; i < ENTRIES; i++)
                     if (!tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_mac[i] = r.src_mac;
                        tbl_port[i] = r.in_port;
                        tbl_stamp[i] = tick_cnt;
                        v.learn_result = LRN_ADDED;
                        break;
                     end
               end
            end
            if ((forward_q & pbit) != 0) begin
               hit = r.dst_mac[40] ? -1 : lookup_mac(r.dst_mac);
               if (hit < 0) begin
                  v.action = ACT_FLOOD;
                  v.out_ports = forward_q & attached_q & ~pbit;
               end else if (tbl_port[hit] == r.in_port ||
                            ((16'd1 << tbl_port[hit]) & attached_q & forward_q) == 0) begin
                  v.action = ACT_DROP;
               end else begin
                  v.action = ACT_UNICAST;
                  v.out_ports = 16'd1 << tbl_port[hit];
               end
            end
         end
      end else begin
         v.action = ACT_DONE;
         if (r.func == FUNC_TICK) tick_cnt = tick_cnt + 16'd1;
         for (int i = 0; i < ENTRIES; i++) begin
            logic kill;
            if (!tbl_valid[i]) continue;
            if (r.func == FUNC_TICK) kill = (16'(tick_cnt - tbl_stamp[i]) >= age_limit_q);
            else if (r.func == FUNC_FLUSH) kill = 1'b1;
            else kill = (tbl_port[i] == r.in_port);
            if (kill) begin
               tbl_valid[i] = 1'b0;
               if (v.removed_count != 9'd511) v.removed_count++;
            end
         end
      end
      return v;
   endfunction

   // driver: one beat per accepted start
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the current beat
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
         frame_req_type r;
         r = pending_reqs.pop_front();
         expected_verdicts = {expected_verdicts, bridge_step(r)};
         start <= 1'b1;
         req_func <= r.func;
         req_in_port <= r.in_port;
         req_dst_mac <= r.dst_mac;
         req_src_mac <= r.src_mac;
         req_ether_type <= r.ether_type;
      end else begin
         start <= 1'b0;
      end
   end

   // prediction is done at issue; the pop above only fires once start is seen accepted
   // because busy is low at the edge that took the previous beat.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_verdicts.size() == 0) begin
            $error("result with no pending request: action %0d", rsp_action);
            errors++;
         end else begin
            verdict_type e;
            e = expected_verdicts.pop_front();
            if (rsp_action !== e.action) begin
               $error("action expected %0d got %0d", e.action, rsp_action);
               errors++;
            end
            if (rsp_out_ports !== e.out_ports) begin
               $error("out_ports expected %h got %h", e.out_ports, rsp_out_ports);
               errors++;
            end
            if (rsp_learn_result !== e.learn_result) begin
               $error("learn_result expected %0d got %0d", e.learn_result,
                      rsp_learn_result);
               errors++;
            end
            if (rsp_removed_count !== e.removed_count) begin
               $error("removed_count expected %0d got %0d", e.removed_count,
                      rsp_removed_count);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_ATTACHED: attached_q = val;
         REG_LEARN:    learn_q = val;
         REG_FORWARD:  forward_q = val;
         default:      age_limit_q = val;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || expected_verdicts.size() != 0 || start || busy)
         @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic queue_req(logic [1:0] f, logic [3:0] p, logic [47:0] d,
                            logic [47:0] s, logic [15:0] et);
      frame_req_type r;
      r = '{f, p, d, s, et};
      pending_reqs = {pending_reqs, r};
   endtask

   // small address pool so hits, refreshes and moves happen often
   function automatic logic [47:0] pick_mac();
      logic [47:0] m;
      case ($urandom_range(9))
         0: m = 48'({$urandom, $urandom});
         1: m = 48'hFFFF_FFFF_FFFF;
         2: m = 48'({$urandom, $urandom}) | 48'h0100_0000_0000;
         default: m = 48'h0200_0000_0000 | $urandom_range(40);
      endcase
      return m;
   endfunction

   task automatic random_phase(int n, int pct, logic [15:0] att, logic [15:0] lrn,
                               logic [15:0] fwd, logic [15:0] age);
      csr_write(REG_ATTACHED, att);
      csr_write(REG_LEARN, lrn);
      csr_write(REG_FORWARD, fwd);
      csr_write(REG_AGE, age);
      idle_pct = pct;
      for (int i = 0; i < n; i++) begin
         int sel;
         logic [1:0] f;
         sel = $urandom_range(99);
         f = sel < 82 ? FUNC_FRAME : sel < 92 ? FUNC_TICK : sel < 94 ? FUNC_FLUSH : FUNC_PURGE;
         queue_req(f, 4'($urandom), pick_mac(), pick_mac(),
                   $urandom_range(9) == 0 ? BPDU_TYPE : 16'($urandom));
      end
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      tick_cnt = '0;
      attached_q = '0; learn_q = '0; forward_q = '0; age_limit_q = 16'd7;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset registers give unknown port
      queue_req(FUNC_FRAME, 4'd0, 48'h0, 48'h0, 16'h0);
      wait_idle();
      csr_write(REG_ATTACHED, 16'hFFFF);
      csr_write(REG_LEARN, 16'h7FFF);
      csr_write(REG_FORWARD, 16'hBFFF);
      csr_write(REG_AGE, 16'd2);
      queue_req(FUNC_FRAME, 4'd1, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 16'h0800);
      queue_req(FUNC_FRAME, 4'd2, 48'h0000_0000_0001, 48'hFEFF_FFFF_FFFF, 16'hFFFF);
      queue_req(FUNC_FRAME, 4'd1, 48'hFEFF_FFFF_FFFF, 48'h0000_0000_0001, 16'h0000);
      queue_req(FUNC_FRAME, 4'd3, 48'h0000_0000_0001, 48'h0000_0000_0001, 16'h86DD);
      queue_req(FUNC_FRAME, 4'd3, 48'h0000_0000_0001, 48'h0000_0000_0001, 16'h86DD);
      queue_req(FUNC_FRAME, 4'd15, 48'h0000_0000_0001, 48'h0100_0000_0000, 16'h0800);
      queue_req(FUNC_FRAME, 4'd14, 48'h0000_0000_0001, 48'h0000_0000_0014, 16'h0800);
      queue_req(FUNC_FRAME, 4'd0, 48'h0000_0000_0014, 48'h0000_0000_0020, 16'h0800);
      queue_req(FUNC_FRAME, 4'd5, 48'h0, 48'h0, BPDU_TYPE);
      queue_req(FUNC_TICK, 4'd0, 48'h0, 48'h0, 16'h0);
      queue_req(FUNC_FRAME, 4'd4, 48'h0, 48'h0000_0000_0020, 16'h0800);
      queue_req(FUNC_TICK, 4'd0, 48'h0, 48'h0, 16'h0);
      queue_req(FUNC_PURGE, 4'd4, 48'h0, 48'h0, 16'h0);
      queue_req(FUNC_FLUSH, 4'd0, 48'h0, 48'h0, 16'h0);
      wait_idle();
      // fill the table past capacity
      csr_write(REG_LEARN, 16'hFFFF);
      csr_write(REG_AGE, 16'hFFFF);
      for (int i = 0; i < ENTRIES + 3; i++)
         queue_req(FUNC_FRAME, 4'(i), 48'h0000_1000_0000 | i, 48'h0000_0000_1000 | i,
                   16'h0800);
      queue_req(FUNC_TICK, 4'd0, 48'h0, 48'h0, 16'h0);
      queue_req(FUNC_FLUSH, 4'd0, 48'h0, 48'h0, 16'h0);
      wait_idle();
      // a run of ticks keeps the tick counter consistent
      for (int i = 0; i < 8; i++) queue_req(FUNC_TICK, 4'd0, 48'h0, 48'h0, 16'h0);
      wait_idle();

      random_phase(200, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd6);
      random_phase(300, 59, 16'h7F7E, 16'hF0F3, 16'h3FFC, 16'd1);
      random_phase(300, 0, 16'($urandom), 16'($urandom), 16'($urandom), 16'd20);
      random_phase(200, 35, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
      random_phase(30, 0, 16'h0000, 16'h0000, 16'h0000, 16'd3);
      random_phase(150, 59, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4);
      drain_done = 1'b1;
   end

   initial begin
      wait (drain_done);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mlft_pkg.sv
hw/rtl/mlft_cell.sv
hw/rtl/mac_learning_forwarding_table.sv
tb/tb_top.sv
